### hw/rtl/mpwa_pkg.sv
// ----------------------------------------------------------------------------
// mpwa_pkg
// shared constants and register indexes for the max pool argmax core
// ----------------------------------------------------------------------------
package mpwa_pkg;

  // default build sizes
  localparam int unsigned MaxOutColsDef = 256;
  localparam int unsigned MaxKernelDef  = 8;
  localparam int unsigned ValueBitsDef  = 16;

  // configuration port
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  // register field widths
  localparam int unsigned KernelBits  = 4;
  localparam int unsigned OutColsBits = 9;
  localparam int unsigned OutRowsBits = 16;
  localparam int unsigned FramesBits  = 16;

  // result offset width
  localparam int unsigned OffsetBits = 3;

  // register reset values
  localparam logic [KernelBits-1:0]  KernelRowsRst = KernelBits'(2);
  localparam logic [KernelBits-1:0]  KernelColsRst = KernelBits'(2);
  localparam logic [OutColsBits-1:0] OutColsRst    = OutColsBits'(256);
  localparam logic [OutRowsBits-1:0] OutRowsRst    = OutRowsBits'(1);
  localparam logic [FramesBits-1:0]  FrameCountRst = FramesBits'(1);

  typedef enum logic [CfgIdxBits-1:0] {
    REG_KERNEL_ROWS = 3'd0,
    REG_KERNEL_COLS = 3'd1,
    REG_OUT_COLS    = 3'd2,
    REG_OUT_ROWS    = 3'd3,
    REG_FRAME_COUNT = 3'd4
  } cfg_reg_e;

endpackage

### hw/rtl/max_pool_window_argmax_core.sv
// ----------------------------------------------------------------------------
// max_pool_window_argmax_core
// max pooling with argmax over non-overlapping windows of a raster stream
// ----------------------------------------------------------------------------
//
// channel   direction  words                        payload
// s_axis    in         one feature pixel            tdata: pixel_value
// m_axis    out        one result per window end    tdata: offset_row,
//                                                   offset_col; tlast:
//                                                   end_of_frame; tuser:
//                                                   end_of_batch
// cfg       in         register write, no wait      cfg_idx_i, cfg_data_i
//
// one pixel per cycle while m_axis takes words; a window-end pixel goes via the
// compare stage into the output register. the per-column best entries live in
// one memory, read on accept and written back from the compare stage, with the
// last write forwarded to the next read. after reset the block takes pixels at
// once; the memory needs no clearing. a word held by m_axis_tready low stops a
// window-end pixel in the compare stage, and s_axis_tready drops in that cycle.
//
module max_pool_window_argmax_core #(
  parameter int unsigned MAX_OUT_COLS = mpwa_pkg::MaxOutColsDef,
  parameter int unsigned KERNEL_LIMIT = mpwa_pkg::MaxKernelDef,
  parameter int unsigned VALUE_BITS   = mpwa_pkg::ValueBitsDef,
  localparam int unsigned InBytes     = (VALUE_BITS + 7) / 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave side
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [InBytes*8-1:0]                s_axis_tdata,   // [VALUE_BITS-1:0] pixel_value
  // master side
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,   // [2:0] offset_row, [5:3] offset_col
  output logic                                m_axis_tlast,   // end_of_frame
  output logic                                m_axis_tuser,   // end_of_batch
  // configuration
  input  logic                                cfg_we_i,
  input  logic [mpwa_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [mpwa_pkg::CfgDataBits-1:0]    cfg_data_i
);

  localparam int unsigned WBits   = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
  localparam int unsigned OcBits  = $clog2(MAX_OUT_COLS + 1);
  localparam int unsigned KBits   = (KERNEL_LIMIT > 1) ? $clog2(KERNEL_LIMIT) : 1;
  localparam int unsigned KcBits  = $clog2(KERNEL_LIMIT + 1);
  localparam int unsigned EntryW  = VALUE_BITS + 2 * KBits;
  localparam int unsigned OffW    = mpwa_pkg::OffsetBits;
  localparam int unsigned RowBits = mpwa_pkg::OutRowsBits;
  localparam int unsigned FrmBits = mpwa_pkg::FramesBits;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [mpwa_pkg::KernelBits-1:0]  kernel_rows_q, kernel_cols_q;
  logic [mpwa_pkg::OutColsBits-1:0] out_cols_q;
  logic [RowBits-1:0]               out_rows_q;
  logic [FrmBits-1:0]               frame_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_rows_q <= mpwa_pkg::KernelRowsRst;
      kernel_cols_q <= mpwa_pkg::KernelColsRst;
      out_cols_q    <= mpwa_pkg::OutColsRst;
      out_rows_q    <= mpwa_pkg::OutRowsRst;
      frame_count_q <= mpwa_pkg::FrameCountRst;
    end else if (cfg_we_i) begin
      case (mpwa_pkg::cfg_reg_e'(cfg_idx_i))
        mpwa_pkg::REG_KERNEL_ROWS: kernel_rows_q <= cfg_data_i[mpwa_pkg::KernelBits-1:0];
        mpwa_pkg::REG_KERNEL_COLS: kernel_cols_q <= cfg_data_i[mpwa_pkg::KernelBits-1:0];
        mpwa_pkg::REG_OUT_COLS:    out_cols_q    <= cfg_data_i[mpwa_pkg::OutColsBits-1:0];
        mpwa_pkg::REG_OUT_ROWS:    out_rows_q    <= cfg_data_i[RowBits-1:0];
        mpwa_pkg::REG_FRAME_COUNT: frame_count_q <= cfg_data_i[FrmBits-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, out-of-range values pinned to the legal span
  logic [KcBits-1:0]  kr, kc;
  logic [OcBits-1:0]  oc;
  logic [RowBits-1:0] orows;
  logic [FrmBits-1:0] fcnt;

  always_comb begin
    if (kernel_rows_q == '0) begin
      kr = KcBits'(1);
    end else if (32'(kernel_rows_q) > 32'(KERNEL_LIMIT)) begin
      kr = KcBits'(KERNEL_LIMIT);
    end else begin
      kr = KcBits'(kernel_rows_q);
    end
    if (kernel_cols_q == '0) begin
      kc = KcBits'(1);
    end else if (32'(kernel_cols_q) > 32'(KERNEL_LIMIT)) begin
      kc = KcBits'(KERNEL_LIMIT);
    end else begin
      kc = KcBits'(kernel_cols_q);
    end
    if (out_cols_q == '0) begin
      oc = OcBits'(1);
    end else if (32'(out_cols_q) > 32'(MAX_OUT_COLS)) begin
      oc = OcBits'(MAX_OUT_COLS);
    end else begin
      oc = OcBits'(out_cols_q);
    end
    orows = (out_rows_q == '0) ? RowBits'(1) : out_rows_q;
    fcnt  = (frame_count_q == '0) ? FrmBits'(1) : frame_count_q;
  end

  // --------------------------------------------------------------------------
  // stage 0: position counters and memory read on accept
  // --------------------------------------------------------------------------
  logic [KBits-1:0]   col_q, col_d, row_q, row_d;
  logic [WBits-1:0]   win_q, win_d;
  logic [RowBits-1:0] wrow_q, wrow_d;
  logic [FrmBits-1:0] frame_q, frame_d;

  logic [KBits-1:0]   c, r;
  logic [WBits-1:0]   w;
  logic               last_col, last_row_in_win, last_win_col, last_row, last_frame;
  logic               c_wrap, w_wrap, r_wrap, wrow_wrap;
  logic               first_px, win_end, eof, eob;
  logic               in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    c = (KcBits'(col_q) >= kc) ? KBits'(kc - KcBits'(1)) : col_q;
    r = (KcBits'(row_q) >= kr) ? KBits'(kr - KcBits'(1)) : row_q;
    w = (OcBits'(win_q) >= oc) ? WBits'(oc - OcBits'(1)) : win_q;

    last_col        = (KcBits'(c) == kc - KcBits'(1));
    last_row_in_win = (KcBits'(r) == kr - KcBits'(1));
    last_win_col    = (OcBits'(w) == oc - OcBits'(1));
    last_row        = ({1'b0, wrow_q} + (RowBits+1)'(1)) >= {1'b0, orows};
    last_frame      = ({1'b0, frame_q} + (FrmBits+1)'(1)) >= {1'b0, fcnt};

    first_px = (r == '0) && (c == '0);
    win_end  = last_row_in_win && last_col;
    eof      = last_win_col && last_row;
    eob      = eof && last_frame;

    c_wrap    = last_col;
    w_wrap    = c_wrap && last_win_col;
    r_wrap    = w_wrap && last_row_in_win;
    wrow_wrap = r_wrap && last_row;

    col_d   = col_q;
    win_d   = win_q;
    row_d   = row_q;
    wrow_d  = wrow_q;
    frame_d = frame_q;
    if (in_acc) begin
      col_d = c_wrap ? '0 : c + KBits'(1);
      win_d = w;
      row_d = r;
      if (c_wrap) begin
        win_d = last_win_col ? '0 : w + WBits'(1);
      end
      if (w_wrap) begin
        row_d = last_row_in_win ? '0 : r + KBits'(1);
      end
      if (r_wrap) begin
        wrow_d = last_row ? '0 : wrow_q + RowBits'(1);
      end
      if (wrow_wrap) begin
        frame_d = last_frame ? '0 : frame_q + FrmBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      win_q   <= '0;
      row_q   <= '0;
      wrow_q  <= '0;
      frame_q <= '0;
    end else begin
      col_q   <= col_d;
      win_q   <= win_d;
      row_q   <= row_d;
      wrow_q  <= wrow_d;
      frame_q <= frame_d;
    end
  end

  // --------------------------------------------------------------------------
  // best-entry memory: {value, row, col} per window column
  // --------------------------------------------------------------------------
  logic [EntryW-1:0] mem [MAX_OUT_COLS];
  logic [EntryW-1:0] rd_data_q;
  logic              wr_en;
  logic [WBits-1:0]  wr_addr;
  logic [EntryW-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= mem[w];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: compare and write back
  // --------------------------------------------------------------------------
  logic                         s1_valid_q;
  logic [WBits-1:0]             s1_w_q;
  logic [KBits-1:0]             s1_r_q, s1_c_q;
  logic                         s1_first_q, s1_end_q, s1_eof_q, s1_eob_q;
  logic signed [VALUE_BITS-1:0] s1_pix_q;

  // last write, forwarded to a read issued in the same cycle
  logic              fwd_valid_q;
  logic [WBits-1:0]  fwd_addr_q;
  logic [EntryW-1:0] fwd_data_q;

  logic                         out_valid_q;
  logic                         s1_go, out_free;
  logic [EntryW-1:0]            best;
  logic signed [VALUE_BITS-1:0] best_val;
  logic                         take;
  logic [EntryW-1:0]            upd;
  logic [KBits-1:0]             upd_r, upd_c;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_go         = s1_valid_q && (!s1_end_q || out_free);
  assign s_axis_tready = !s1_valid_q || s1_go;

  always_comb begin
    best     = (fwd_valid_q && (fwd_addr_q == s1_w_q)) ? fwd_data_q : rd_data_q;
    best_val = best[EntryW-1 -: VALUE_BITS];
    take     = s1_first_q || (s1_pix_q > best_val);
    upd      = take ? {s1_pix_q, s1_r_q, s1_c_q} : best;
    upd_r    = upd[2*KBits-1:KBits];
    upd_c    = upd[KBits-1:0];
    wr_en    = s1_go && take;
    wr_addr  = s1_w_q;
    wr_data  = upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (wr_en) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_w_q     <= w;
      s1_r_q     <= r;
      s1_c_q     <= c;
      s1_first_q <= first_px;
      s1_end_q   <= win_end;
      s1_eof_q   <= eof;
      s1_eob_q   <= eob;
      s1_pix_q   <= s_axis_tdata[VALUE_BITS-1:0];
    end
    if (wr_en) begin
      fwd_addr_q <= wr_addr;
      fwd_data_q <= wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic [OffW-1:0] out_row_q, out_col_q;
  logic            out_eof_q, out_eob_q;
  logic            out_load;

  assign out_load = s1_go && s1_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q <= OffW'(upd_r);
      out_col_q <= OffW'(upd_c);
      out_eof_q <= s1_eof_q;
      out_eob_q <= s1_eob_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_col_q, out_row_q};
  assign m_axis_tlast  = out_eof_q;
  assign m_axis_tuser  = out_eob_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a result appears only after a window-end pixel left the compare stage
  a_out_from_win_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_end_q))
    else $error("result word without a window end");

  // a stuck compare stage blocks the input
  a_stall_blocks_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |-> !s_axis_tready)
    else $error("pixel taken while compare stage is stalled");

  // batch end only ever comes with frame end
  a_eob_has_eof : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("end of batch without end of frame");

  // a held result word stays while a non-final pixel waits in the compare stage
  a_no_mid_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_end_q && out_valid_q && !m_axis_tready) |=> out_valid_q)
    else $error("held result word dropped");

endmodule

### bench/tb_max_pool_window_argmax_core.sv
// ----------------------------------------------------------------------------
// tb_max_pool_window_argmax_core
// self-checking bench for the max pool argmax core: random and corner pixels
// go through a queue-fed driver, a local window tracker predicts each argmax
// word, and the monitor checks the offsets and end flags as they come out
// ----------------------------------------------------------------------------
module tb_max_pool_window_argmax_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PixBits     = mpwa_pkg::ValueBitsDef;
  localparam int unsigned MaxKernel   = mpwa_pkg::MaxKernelDef;
  localparam int unsigned MaxOutCols  = mpwa_pkg::MaxOutColsDef;
  localparam int unsigned IdxBits     = mpwa_pkg::CfgIdxBits;
  localparam int unsigned DataBits    = mpwa_pkg::CfgDataBits;
  localparam int unsigned OffBits     = mpwa_pkg::OffsetBits;
  localparam int unsigned RandItems   = 900;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StallLimit  = 5000;
  localparam logic [IdxBits-1:0] RegUnused = IdxBits'(7);

  typedef struct packed {
    logic [OffBits-1:0] row;
    logic [OffBits-1:0] col;
    logic               eof;
    logic               eob;
  } argmax_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PixBits-1:0]    s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [IdxBits-1:0]    cfg_idx_i = '0;
  logic [DataBits-1:0]   cfg_data_i = '0;

  // register copies as written, clamped on use
  logic [mpwa_pkg::KernelBits-1:0]  kr_reg = mpwa_pkg::KernelRowsRst;
  logic [mpwa_pkg::KernelBits-1:0]  kc_reg = mpwa_pkg::KernelColsRst;
  logic [mpwa_pkg::OutColsBits-1:0] oc_reg = mpwa_pkg::OutColsRst;
  logic [mpwa_pkg::OutRowsBits-1:0] orows_reg = mpwa_pkg::OutRowsRst;
  logic [mpwa_pkg::FramesBits-1:0]  frames_reg = mpwa_pkg::FrameCountRst;

  logic signed [PixBits-1:0] best_val [MaxOutCols];
  logic [OffBits-1:0]        best_r [MaxOutCols];
  logic [OffBits-1:0]        best_c [MaxOutCols];
  int unsigned col_cnt = 0, win_cnt = 0, row_cnt = 0, wrow_cnt = 0, frame_cnt = 0;

  logic [PixBits-1:0] pixel_q [$];
  argmax_t            argmax_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;

  max_pool_window_argmax_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned eff_val(input int unsigned v, input int unsigned hi);
    if (v < 1) begin
      return 1;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // step a counter, true when it wraps
  function automatic bit bump(inout int unsigned cnt, input int unsigned lim);
    if (cnt + 1 >= lim) begin
      cnt = 0;
      return 1'b1;
    end
    cnt = cnt + 1;
    return 1'b0;
  endfunction

  // track one pixel through its window, queue the argmax word on window end
  function automatic void pool_pixel(input logic signed [PixBits-1:0] px);
    int unsigned kr, kc, oc, nrows, nframes, r, c, w;
    bit last_col, last_row, last_frame;
    argmax_t res;
    kr = eff_val(kr_reg, MaxKernel);
    kc = eff_val(kc_reg, MaxKernel);
    oc = eff_val(oc_reg, MaxOutCols);
    nrows = eff_val(orows_reg, 16'hFFFF);
    nframes = eff_val(frames_reg, 16'hFFFF);
    r = (row_cnt >= kr) ? kr - 1 : row_cnt;
    c = (col_cnt >= kc) ? kc - 1 : col_cnt;
    w = (win_cnt >= oc) ? oc - 1 : win_cnt;
    last_col = (w == oc - 1);
    last_row = (wrow_cnt + 1 >= nrows);
    last_frame = (frame_cnt + 1 >= nframes);
    if (r == 0 && c == 0) begin
      best_val[w] = px;
      best_r[w] = '0;
      best_c[w] = '0;
    end else if (px > best_val[w]) begin
      // strictly greater only, an equal value keeps the earlier position
      best_val[w] = px;
      best_r[w] = OffBits'(r);
      best_c[w] = OffBits'(c);
    end
    if (r == kr - 1 && c == kc - 1) begin
      res.row = best_r[w];
      res.col = best_c[w];
      res.eof = last_col && last_row;
      res.eob = res.eof && last_frame;
      argmax_q.push_back(res);
    end
    col_cnt = c;
    win_cnt = w;
    row_cnt = r;
    if (bump(col_cnt, kc)) begin
      if (bump(win_cnt, oc)) begin
        if (bump(row_cnt, kr)) begin
          if (bump(wrow_cnt, nrows)) begin
            void'(bump(frame_cnt, nframes));
          end
        end
      end
    end
  endfunction

  function automatic logic [PixBits-1:0] rand_pixel();
    case ($urandom_range(9))
      0: return {1'b1, {(PixBits-1){1'b0}}};
      1: return {1'b0, {(PixBits-1){1'b1}}};
      2, 3: return PixBits'($urandom_range(2)) - PixBits'(1);
      default: return PixBits'($urandom);
    endcase
  endfunction

  // corner windows 0..3 of the first window row under the reset geometry:
  // all minimum, tie at maximum, max in lower left, max in lower right
  function automatic logic [PixBits-1:0] corner_pixel(input int unsigned i);
    case (i)
      0, 1, 2, 7, 512, 513, 518: return 16'h8000;
      3, 514, 515, 519:          return 16'h7FFF;
      4:                         return 16'h0000;
      5, 6:                      return 16'hFFFF;
      516, 517:                  return 16'h0001;
      default:                   return rand_pixel();
    endcase
  endfunction

  function automatic logic [DataBits-1:0] kernel_word();
    if ($urandom_range(3) == 0) begin
      return DataBits'($urandom);
    end
    return DataBits'($urandom_range(8, 1));
  endfunction

  function automatic logic [DataBits-1:0] count_word();
    if ($urandom_range(7) == 0) begin
      return 16'hFFFF;
    end
    return DataBits'($urandom_range(4));
  endfunction

  task automatic write_reg(input logic [IdxBits-1:0] idx, input logic [DataBits-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      mpwa_pkg::REG_KERNEL_ROWS: kr_reg = val[mpwa_pkg::KernelBits-1:0];
      mpwa_pkg::REG_KERNEL_COLS: kc_reg = val[mpwa_pkg::KernelBits-1:0];
      mpwa_pkg::REG_OUT_COLS:    oc_reg = val[mpwa_pkg::OutColsBits-1:0];
      mpwa_pkg::REG_OUT_ROWS:    orows_reg = val[mpwa_pkg::OutRowsBits-1:0];
      mpwa_pkg::REG_FRAME_COUNT: frames_reg = val[mpwa_pkg::FramesBits-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(input logic [DataBits-1:0] kr, input logic [DataBits-1:0] kc,
                              input logic [DataBits-1:0] oc, input logic [DataBits-1:0] nr,
                              input logic [DataBits-1:0] nf);
    write_reg(mpwa_pkg::REG_KERNEL_ROWS, kr);
    write_reg(mpwa_pkg::REG_KERNEL_COLS, kc);
    write_reg(mpwa_pkg::REG_OUT_COLS, oc);
    write_reg(mpwa_pkg::REG_OUT_ROWS, nr);
    write_reg(mpwa_pkg::REG_FRAME_COUNT, nf);
  endtask

  // whole window rows only, so a later register change starts on a clean window
  task automatic feed_window_rows(input int unsigned n, output int unsigned fed);
    fed = n * eff_val(oc_reg, MaxOutCols) * eff_val(kc_reg, MaxKernel)
          * eff_val(kr_reg, MaxKernel);
    for (int unsigned i = 0; i < fed; i++) begin
      pixel_q.push_back(rand_pixel());
    end
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pixel_q.size() != 0 || s_axis_tvalid || argmax_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 74; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 74; end
      default: begin send_idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  // pixel driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pool_pixel(s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pixel_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // argmax word monitor and receiver backpressure
  always @(posedge clk_i) begin
    argmax_t exp_res;
    if (rst_ni) begin
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_seen != hold_req && m_axis_tvalid) begin
        // long hold once a word is waiting, the input side must back up
        hold_seen <= hold_req;
        hold_left <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (argmax_q.size() == 0) begin
          $error("unexpected word: offset_row %0d offset_col %0d eof %0b eob %0b",
                 m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tlast, m_axis_tuser);
          mismatch_cnt = mismatch_cnt + 1;
        end else begin
          exp_res = argmax_q.pop_front();
          if (m_axis_tdata[2:0] !== exp_res.row) begin
            $error("offset_row: expected %0d, got %0d", exp_res.row, m_axis_tdata[2:0]);
            mismatch_cnt = mismatch_cnt + 1;
          end
          if (m_axis_tdata[5:3] !== exp_res.col) begin
            $error("offset_col: expected %0d, got %0d", exp_res.col, m_axis_tdata[5:3]);
            mismatch_cnt = mismatch_cnt + 1;
          end
          if (m_axis_tlast !== exp_res.eof) begin
            $error("end_of_frame: expected %0b, got %0b", exp_res.eof, m_axis_tlast);
            mismatch_cnt = mismatch_cnt + 1;
          end
          if (m_axis_tuser !== exp_res.eob) begin
            $error("end_of_batch: expected %0b, got %0b", exp_res.eob, m_axis_tuser);
            mismatch_cnt = mismatch_cnt + 1;
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_no;
    int unsigned random_fed;
    int unsigned fed;
    int unsigned ppr;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: 2x2 windows, 256 per row, one row, one frame
    set_idling(0);
    hold_req = hold_req + 1;
    for (int unsigned i = 0; i < 1024; i++) begin
      pixel_q.push_back(corner_pixel(i));
    end
    wait_idle();

    // 1x1 windows, every pixel is a word, frame ends every 3, batch every 6
    set_geometry(16'd1, 16'd1, 16'd1, 16'd3, 16'd2);
    pixel_q.push_back(16'h7FFF);
    pixel_q.push_back(16'h8000);
    pixel_q.push_back(16'h0000);
    pixel_q.push_back(16'hFFFF);
    pixel_q.push_back(16'h0001);
    pixel_q.push_back(16'h7FFF);
    wait_idle();

    // zero registers act as one; unused index must change nothing
    set_geometry(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    write_reg(RegUnused, 16'hFFFF);
    pixel_q.push_back(16'h8000);
    pixel_q.push_back(16'h7FFF);
    wait_idle();

    // oversized kernels clamp to 8x8, then shrink out_rows below the count
    set_geometry(16'd15, 16'hFFF9, 16'd1, 16'd2, 16'hFFFF);
    feed_window_rows(1, fed);
    wait_idle();
    write_reg(mpwa_pkg::REG_OUT_ROWS, 16'd1);
    feed_window_rows(1, fed);
    wait_idle();

    phase_no = 0;
    random_fed = 0;
    while (random_fed < RandItems) begin
      if ($urandom_range(7) == 0) begin
        write_reg(mpwa_pkg::REG_KERNEL_ROWS, DataBits'($urandom_range(1)));
        write_reg(mpwa_pkg::REG_KERNEL_COLS, DataBits'($urandom_range(1)));
        write_reg(mpwa_pkg::REG_OUT_COLS,
                  ($urandom_range(1) == 0) ? 16'd256 : DataBits'($urandom));
      end else begin
        if ($urandom_range(1) == 0) begin
          write_reg(mpwa_pkg::REG_KERNEL_ROWS, kernel_word());
        end
        if ($urandom_range(1) == 0) begin
          write_reg(mpwa_pkg::REG_KERNEL_COLS, kernel_word());
        end
        if (eff_val(oc_reg, MaxOutCols) > 8 || $urandom_range(1) == 0) begin
          write_reg(mpwa_pkg::REG_OUT_COLS, DataBits'($urandom_range(8)));
        end
      end
      if ($urandom_range(1) == 0) begin
        write_reg(mpwa_pkg::REG_OUT_ROWS, count_word());
      end
      if ($urandom_range(1) == 0) begin
        write_reg(mpwa_pkg::REG_FRAME_COUNT, count_word());
      end
      if ($urandom_range(5) == 0) begin
        write_reg(RegUnused - IdxBits'($urandom_range(2)), DataBits'($urandom));
      end
      set_idling(phase_no);
      if (phase_no % 5 == 2) begin
        hold_req = hold_req + 1;
      end
      ppr = eff_val(oc_reg, MaxOutCols) * eff_val(kc_reg, MaxKernel)
            * eff_val(kr_reg, MaxKernel);
      feed_window_rows($urandom_range((ppr >= 300) ? 1 : 300 / ppr, 1), fed);
      random_fed = random_fed + fed;
      wait_idle();
      phase_no = phase_no + 1;
    end

    if (mismatch_cnt == 0 && argmax_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
